FILE: hw/rtl/char_lcd_text_writer_defines.svh
// Assertion macros shared by the character LCD writer RTL.
`ifndef CHAR_LCD_TEXT_WRITER_DEFINES_SVH
`define CHAR_LCD_TEXT_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CLCD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CLCD_ASSERT(label, prop, msg)
`define CLCD_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: hw/rtl/clcd_pkg.sv
// Types, codes and constant tables of the character LCD writer.
package clcd_pkg;

  localparam int unsigned IDX_W = 4;

  localparam logic [1:0] OP_TEXT   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DDRAM_CMD    = 8'h80;
  localparam logic [7:0] WAKE_CMD     = 8'h30;
  localparam logic [7:0] WIDTH4_CMD   = 8'h20;
  localparam logic [7:0] FUNC4_CMD    = 8'h28;
  localparam logic [7:0] FUNC8_CMD    = 8'h38;
  localparam logic [7:0] DISPLAY_CMD  = 8'h0F;
  localparam logic [7:0] CLEAR_CMD    = 8'h01;
  localparam logic [7:0] ENTRY_CMD    = 8'h06;

  localparam logic [4:0] FIRST_WAIT_BEFORE = 5'd20;
  localparam logic [3:0] FIRST_WAIT_AFTER  = 4'd8;
  localparam logic [3:0] WAKE_WAIT_AFTER   = 4'd4;
  localparam logic [3:0] STROBE_WAIT      = 4'd3;

  localparam logic [IDX_W-1:0] INIT_COUNT_4 = 4'd12;
  localparam logic [IDX_W-1:0] INIT_COUNT_8 = 4'd8;
  localparam logic [IDX_W-1:0] PREAMBLE_LEN = 4'd4;

  typedef struct packed {
    logic             init;
    logic             four;
    logic [7:0]       data;
    logic             rs;
    logic [IDX_W-1:0] idx;
  } job_t;

  function automatic logic [7:0] line_base(input logic [1:0] line);
    logic [7:0] base;
    unique case (line)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [1:0] sel, input logic four);
    logic [7:0] cmd;
    unique case (sel)
      2'd0: cmd = four ? FUNC4_CMD : FUNC8_CMD;
      2'd1: cmd = DISPLAY_CMD;
      2'd2: cmd = CLEAR_CMD;
      default: cmd = ENTRY_CMD;
    endcase
    return cmd;
  endfunction

endpackage

FILE: hw/rtl/clcd_in_if.sv
// Handshake channel that carries one LCD request item.
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;
  logic       first_of_text;
  logic [7:0] column;
  logic [7:0] row;

  modport source (output valid, op, char_code, first_of_text, column, row, input ready);
  modport sink (input valid, op, char_code, first_of_text, column, row, output ready);
endinterface

FILE: hw/rtl/clcd_out_if.sv
// Handshake channel that carries one LCD bus strobe item.
interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_value;
  logic       register_select;
  logic [4:0] wait_before_ms;
  logic [3:0] wait_after_ms;
  logic       last;

  modport source (output valid, bus_value, register_select, wait_before_ms, wait_after_ms,
                  last, input ready);
  modport sink (input valid, bus_value, register_select, wait_before_ms, wait_after_ms,
                last, output ready);
endinterface

FILE: hw/rtl/char_lcd_text_writer.sv
// Character LCD writer: turns request items into bus strobe items.
//
//   channel      dir   carries
//   item_in      in    op, char_code, first_of_text, column, row
//   strobe_out   out   bus_value, register_select, waits, last
//   cfg_write_*  in    four_bit_bus mode bit
//
// One strobe leaves the output register per cycle while strobe_out is ready. An item gives
// 1 strobe for text or cursor in 8-bit mode, 2 in 4-bit mode, 8 or 12 for init.
// An item with the unused op code is taken and gives no strobe.
// The next item is taken in the cycle its predecessor's last strobe is registered.
// Reset clears the line counter, selects the 8-bit bus and empties both registers.
// A low ready on strobe_out holds the output item and the pending request.
`include "char_lcd_text_writer_defines.svh"

module char_lcd_text_writer (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write_enable,
  input logic        cfg_write_data,
  clcd_in_if.sink    item_in,
  clcd_out_if.source strobe_out
);

  logic                      four_bit_bus;
  logic [1:0]                line_index;
  logic [1:0]                line_next;
  logic                      job_valid;
  clcd_pkg::job_t            job;
  clcd_pkg::job_t            job_next;
  logic [clcd_pkg::IDX_W-1:0] job_count;
  logic [clcd_pkg::IDX_W-1:0] idx_rel;
  logic [7:0]                full_byte;
  logic [7:0]                strobe_bus;
  logic                      strobe_last;
  logic                      preamble;
  logic                      out_free;
  logic                      emit;
  logic                      accept;

  assign out_free = !strobe_out.valid || strobe_out.ready;
  assign emit = job_valid && out_free;
  assign item_in.ready = !job_valid || (emit && strobe_last);
  assign accept = item_in.valid && item_in.ready;

  always_comb begin
    line_next = (item_in.first_of_text ? 2'd0 : line_index) + 2'd1;
    job_next = '0;
    job_next.four = four_bit_bus;
    unique case (item_in.op)
      clcd_pkg::OP_TEXT: begin
        if (item_in.char_code == clcd_pkg::NEWLINE_CODE) begin
          job_next.data = clcd_pkg::DDRAM_CMD + clcd_pkg::line_base(line_next);
        end else begin
          job_next.data = item_in.char_code;
          job_next.rs = 1'b1;
        end
      end
      clcd_pkg::OP_CURSOR: begin
        job_next.data = clcd_pkg::DDRAM_CMD + clcd_pkg::line_base(item_in.row[1:0])
                        + item_in.column;
      end
      clcd_pkg::OP_INIT: begin
        job_next.init = 1'b1;
      end
      default: begin
        job_next.init = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (job.init) begin
      job_count = job.four ? clcd_pkg::INIT_COUNT_4 : clcd_pkg::INIT_COUNT_8;
    end else begin
      job_count = job.four ? 4'd2 : 4'd1;
    end
    idx_rel = job.idx - clcd_pkg::PREAMBLE_LEN;
    preamble = job.init && (job.idx < clcd_pkg::PREAMBLE_LEN);
    if (!job.init) begin
      full_byte = job.data;
    end else if (preamble) begin
      full_byte = (job.idx == 4'd3 && job.four) ? clcd_pkg::WIDTH4_CMD : clcd_pkg::WAKE_CMD;
    end else begin
      full_byte = clcd_pkg::init_cmd(job.four ? idx_rel[2:1] : idx_rel[1:0], job.four);
    end
    if (!job.four || preamble) begin
      strobe_bus = full_byte;
    end else if (job.idx[0]) begin
      strobe_bus = {full_byte[3:0], 4'b0000};
    end else begin
      strobe_bus = {full_byte[7:4], 4'b0000};
    end
    strobe_last = job.idx == job_count - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_bus <= 1'b0;
      line_index <= 2'd0;
      job_valid <= 1'b0;
      strobe_out.valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        four_bit_bus <= cfg_write_data;
      end
      if (accept) begin
        job_valid <= item_in.op != clcd_pkg::OP_UNUSED;
        if (item_in.op == clcd_pkg::OP_TEXT) begin
          if (item_in.char_code == clcd_pkg::NEWLINE_CODE) begin
            line_index <= line_next;
          end else if (item_in.first_of_text) begin
            line_index <= 2'd0;
          end
        end
      end else if (emit && strobe_last) begin
        job_valid <= 1'b0;
      end
      if (emit) begin
        strobe_out.valid <= 1'b1;
      end else if (strobe_out.ready) begin
        strobe_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end else if (emit) begin
      job.idx <= job.idx + 4'd1;
    end
    if (emit) begin
      strobe_out.bus_value <= strobe_bus;
      strobe_out.register_select <= !job.init && job.rs;
      strobe_out.wait_before_ms <= (job.init && job.idx == 4'd0) ?
                                   clcd_pkg::FIRST_WAIT_BEFORE : 5'd0;
      if (job.init && job.idx == 4'd0) begin
        strobe_out.wait_after_ms <= clcd_pkg::FIRST_WAIT_AFTER;
      end else if (job.init && (job.idx == 4'd1 || job.idx == 4'd2)) begin
        strobe_out.wait_after_ms <= clcd_pkg::WAKE_WAIT_AFTER;
      end else begin
        strobe_out.wait_after_ms <= clcd_pkg::STROBE_WAIT;
      end
      strobe_out.last <= strobe_last;
    end
  end

  `CLCD_ASSERT(a_idx_in_range, job_valid |-> (job.idx < job_count), "strobe index past end")
  `CLCD_ASSERT(a_job_loaded,
               (accept && item_in.op != clcd_pkg::OP_UNUSED) |=> job_valid,
               "item not loaded")
  `CLCD_ASSERT(a_first_wait,
               (strobe_out.valid && strobe_out.wait_before_ms != 5'd0) |->
               (strobe_out.bus_value == clcd_pkg::WAKE_CMD && !strobe_out.register_select),
               "bad first init strobe")
  `CLCD_ASSERT(a_data_wait,
               (strobe_out.valid && strobe_out.register_select) |->
               (strobe_out.wait_after_ms == clcd_pkg::STROBE_WAIT),
               "bad data strobe wait")
  `CLCD_ASSERT_RST(a_reset_empty, rst |=> (!job_valid && !strobe_out.valid), "not empty after reset")

endmodule
